[hw/rtl/fwgs_pkg.sv]
package fwgs_pkg;

	// Operation codes carried by the mode field of an input item.
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_SWEEP = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RANDOM_SEED = 2'd2;

	localparam int CFG_DATA_W = 16;
	localparam int SIZE_W     = 7;
	localparam int LFSR_W     = 16;

	localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_RESET = 16'h0001;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_USE,
		ST_SW_RD_HERE,
		ST_SW_RD_UP,
		ST_SW_LOAD,
		ST_SW_CELL,
		ST_SW_WRITE,
		ST_DONE
	} state_t;

	// Outcome of one cell rule evaluation.
	typedef struct packed {
		logic draw;
		logic set_here;
		logic set_left;
		logic set_right;
		logic clr_here;
		logic clr_up;
		logic moved;
	} cell_act_t;

endpackage

[hw/rtl/fwgs_row_mem.sv]
module fwgs_row_mem
	import fwgs_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/fwgs_cell_unit.sv]
module fwgs_cell_unit
	import fwgs_pkg::*;
(
	input  logic      here,
	input  logic      up,
	input  logic      left,
	input  logic      right,
	input  logic      has_up,
	input  logic      has_left,
	input  logic      has_right,
	input  logic      side_bit,
	output cell_act_t act
);

	logic fall;
	logic slide_l;
	logic slide_r;
	logic draw;
	logic side_l;
	logic side_r;

	// Rules are tried in priority order; the sideways rule only runs when
	// none of the rules involving the cell above fired.
	always_comb begin
		fall    = has_up & ~here & up;
		slide_l = has_up & has_left & here & up & ~left;
		slide_r = has_up & has_right & here & up & ~right & ~slide_l;
		draw    = ~(fall | slide_l | slide_r);
		side_l  = draw & side_bit & has_left & here & ~left;
		side_r  = draw & ~side_bit & has_right & here & ~right;

		act.draw      = draw;
		act.set_here  = fall;
		act.set_left  = slide_l | side_l;
		act.set_right = slide_r | side_r;
		act.clr_here  = side_l | side_r;
		act.clr_up    = fall | slide_l | slide_r;
		act.moved     = fall | slide_l | slide_r | side_l | side_r;
	end

endmodule

[hw/rtl/falling_water_grid_sweep.sv]
// Falling water grid engine: a one-bit grid of water and empty cells, row 0 at the top.
// Input channel (in_valid/in_ready) carries one item with mode, row, col and
// cell_in. Mode write stores cell_in, mode read returns the cell on cell_out,
// mode sweep runs one pass from the bottom-right to the top-left cell and
// returns on moved whether any water moved. Every item gives exactly one
// result item on the output channel (out_valid/out_ready).
// The grid is held as one memory row per grid row. A cell write or read takes
// a row read and, for a write, a row write, in states ACC_RD and ACC_USE before
// DONE; a cell outside the used area or mode 3 goes from IDLE straight to DONE.
// A sweep loads the current row and the row above into two row registers, steps
// one cell per cycle through a single rule unit, then writes the row back, row
// by row from the bottom. The block works on one item at a time; in_ready is low
// from accept until the result has moved into the output register, and rises the
// cycle after.
// Reset clears the configuration to a 64 by 64 grid and seed 1, then a
// clearing pass writes every memory row to empty, one row per cycle; no item
// is accepted meanwhile, configuration writes are.
// A stalled receiver holds the result in the output register; the next item
// can be accepted while it waits, but its own result waits behind it.
module falling_water_grid_sweep
	import fwgs_pkg::*;
#(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [5:0]            row,
	input  logic [5:0]            col,
	input  logic                  cell_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  cell_out,
	output logic                  moved
);

	localparam int CW  = $clog2(MAX_COLS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CW1 = $clog2(MAX_COLS + 1);
	localparam int RW1 = $clog2(MAX_ROWS + 1);

	state_t state_q, state_d;

	logic [SIZE_W-1:0] grid_width_q;
	logic [SIZE_W-1:0] grid_height_q;
	logic [LFSR_W-1:0] lfsr_q;

	logic [1:0]        mode_q;
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic              cell_q;
	logic [RW-1:0]     clr_q;
	logic [RW-1:0]     r_q;
	logic [CW-1:0]     c_q;
	logic [MAX_COLS-1:0] here_q;
	logic [MAX_COLS-1:0] up_q;
	logic              res_cell_q;
	logic              res_moved_q;
	logic              out_valid_q;
	logic              out_cell_q;
	logic              out_moved_q;

	logic [CW1-1:0]    used_cols;
	logic [RW1-1:0]    used_rows;
	logic              in_area;
	logic              accept;
	logic              slot_free;

	logic              mem_rd_en;
	logic [RW-1:0]     mem_rd_addr;
	logic [MAX_COLS-1:0] mem_rd_data;
	logic              mem_wr_en;
	logic [RW-1:0]     mem_wr_addr;
	logic [MAX_COLS-1:0] mem_wr_data;
	logic [MAX_COLS-1:0] acc_row;

	logic [CW-1:0]     c_lft;
	logic [CW-1:0]     c_rgt;
	logic              has_up;
	logic              has_left;
	logic              has_right;
	logic              nb_left;
	logic              nb_right;
	cell_act_t         act;

	// Sizes above the memory limits are used as the limits.
	always_comb begin
		if (32'(grid_width_q) > 32'(MAX_COLS)) begin
			used_cols = CW1'(MAX_COLS);
		end else begin
			used_cols = CW1'(grid_width_q);
		end
		if (32'(grid_height_q) > 32'(MAX_ROWS)) begin
			used_rows = RW1'(MAX_ROWS);
		end else begin
			used_rows = RW1'(grid_height_q);
		end
	end

	assign in_area   = (32'(row) < 32'(used_rows)) && (32'(col) < 32'(used_cols));
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Neighbors of the current cell in the row registers. A missing
	// neighbor reads as water so that no rule can move into it.
	assign c_lft     = c_q - CW'(1);
	assign c_rgt     = c_q + CW'(1);
	assign has_up    = (r_q != '0);
	assign has_left  = (c_q != '0);
	assign has_right = (32'(c_q) + 32'd1) < 32'(used_cols);
	assign nb_left   = has_left ? here_q[c_lft] : 1'b1;
	assign nb_right  = has_right ? here_q[c_rgt] : 1'b1;

	fwgs_cell_unit u_cell (
		.here      (here_q[c_q]),
		.up        (up_q[c_q]),
		.left      (nb_left),
		.right     (nb_right),
		.has_up    (has_up),
		.has_left  (has_left),
		.has_right (has_right),
		.side_bit  (lfsr_q[0]),
		.act       (act)
	);

	fwgs_row_mem #(
		.DEPTH (MAX_ROWS),
		.WIDTH (MAX_COLS)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	always_comb begin
		acc_row        = mem_rd_data;
		acc_row[col_q] = cell_q;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, memory port control and input handshake.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = r_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = r_q;
		mem_wr_data = here_q;
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_q;
				mem_wr_data = '0;
				if (clr_q == RW'(MAX_ROWS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if ((mode == MODE_WRITE || mode == MODE_READ) && in_area) begin
						state_d = ST_ACC_RD;
					end else if (mode == MODE_SWEEP && used_cols != '0 &&
						used_rows != '0) begin
						state_d = ST_SW_RD_HERE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_ACC_RD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = row_q;
				state_d     = ST_ACC_USE;
			end
			ST_ACC_USE: begin
				if (mode_q == MODE_WRITE) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = row_q;
					mem_wr_data = acc_row;
				end
				state_d = ST_DONE;
			end
			ST_SW_RD_HERE: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = r_q;
				state_d     = ST_SW_RD_UP;
			end
			ST_SW_RD_UP: begin
				mem_rd_en   = has_up;
				mem_rd_addr = r_q - RW'(1);
				state_d     = ST_SW_LOAD;
			end
			ST_SW_LOAD: begin
				state_d = ST_SW_CELL;
			end
			ST_SW_CELL: begin
				if (c_q == '0) begin
					state_d = ST_SW_WRITE;
				end
			end
			ST_SW_WRITE: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = r_q;
				mem_wr_data = here_q;
				mem_rd_en   = (32'(r_q) >= 32'd2);
				mem_rd_addr = r_q - RW'(2);
				if (r_q == '0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SW_LOAD;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration registers and the side-choice LFSR.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= SIZE_W'(64);
			grid_height_q <= SIZE_W'(64);
			lfsr_q        <= LFSR_RESET;
		end else begin
			if (cfg_wr_en && cfg_index == REG_GRID_WIDTH) begin
				grid_width_q <= cfg_data[SIZE_W-1:0];
			end
			if (cfg_wr_en && cfg_index == REG_GRID_HEIGHT) begin
				grid_height_q <= cfg_data[SIZE_W-1:0];
			end
			if (cfg_wr_en && cfg_index == REG_RANDOM_SEED) begin
				// A zero seed would lock the LFSR, so it loads as one.
				lfsr_q <= (cfg_data == '0) ? LFSR_RESET : cfg_data;
			end else if (state_q == ST_SW_CELL && act.draw) begin
				lfsr_q <= {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_MASK : '0);
			end
		end
	end

	// Control counters and the result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			res_cell_q  <= 1'b0;
			res_moved_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_cell_q  <= 1'b0;
			out_moved_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + RW'(1);
			end
			if (accept) begin
				res_cell_q  <= 1'b0;
				res_moved_q <= 1'b0;
			end
			if (state_q == ST_ACC_USE && mode_q == MODE_READ) begin
				res_cell_q <= mem_rd_data[col_q];
			end
			if (state_q == ST_SW_CELL && act.moved) begin
				res_moved_q <= 1'b1;
			end
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
				out_cell_q  <= res_cell_q;
				out_moved_q <= res_moved_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item fields, sweep position and the two row registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			row_q  <= RW'(row);
			col_q  <= CW'(col);
			cell_q <= cell_in;
			r_q    <= RW'(used_rows - RW1'(1));
		end
		case (state_q)
			ST_SW_RD_UP: begin
				here_q <= mem_rd_data;
			end
			ST_SW_LOAD: begin
				up_q <= has_up ? mem_rd_data : '0;
				c_q  <= CW'(used_cols - CW1'(1));
			end
			ST_SW_CELL: begin
				if (act.clr_here) begin
					here_q[c_q] <= 1'b0;
				end
				if (act.set_here) begin
					here_q[c_q] <= 1'b1;
				end
				if (act.set_left) begin
					here_q[c_lft] <= 1'b1;
				end
				if (act.set_right) begin
					here_q[c_rgt] <= 1'b1;
				end
				if (act.clr_up) begin
					up_q[c_q] <= 1'b0;
				end
				c_q <= c_q - CW'(1);
			end
			ST_SW_WRITE: begin
				here_q <= up_q;
				r_q    <= r_q - RW'(1);
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign cell_out  = out_cell_q;
	assign moved     = out_moved_q;

`ifndef SYNTHESIS
	a_one_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(cell_out && moved))
		else $error("result carries both a cell value and a moved flag");

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("side-choice LFSR reached zero");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SW_CELL |-> 32'(c_q) < 32'(used_cols))
		else $error("sweep column outside the used width");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SW_CELL |-> 32'(r_q) < 32'(used_rows))
		else $error("sweep row outside the used height");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in work");
`endif

endmodule

[sim/falling_water_grid_sweep_test.sv]
import fwgs_pkg::*;

// One readout of the block: the cell value for a read and the moved flag for a sweep.
typedef struct {
	bit cell_out;
	bit moved;
} cell_readout_t;

// Keeps a private copy of the water grid, the size registers and the side-choice
// shift register, and works out the readout that each accepted item must produce.
class water_scoreboard;
	localparam int ROWS = 64;
	localparam int COLS = 64;

	bit            cells[ROWS][COLS];
	logic [6:0]    width;
	logic [6:0]    height;
	logic [15:0]   side_bits;
	cell_readout_t readouts_due[$];
	int            errors;
	int            checked;
	int            sweeps;
	int            sweeps_moved;
	int            water_reads;

	function new();
		foreach (cells[r, c])
			cells[r][c] = 1'b0;
		width = 7'd64;
		height = 7'd64;
		side_bits = LFSR_RESET;
		errors = 0;
		checked = 0;
		sweeps = 0;
		sweeps_moved = 0;
		water_reads = 0;
	endfunction

	function int cols_in_use();
		return (width > COLS) ? COLS : int'(width);
	endfunction

	function int rows_in_use();
		return (height > ROWS) ? ROWS : int'(height);
	endfunction

	function void write_register(logic [1:0] index, logic [15:0] data);
		case (index)
		REG_GRID_WIDTH: width = data[6:0];
		REG_GRID_HEIGHT: height = data[6:0];
		REG_RANDOM_SEED: side_bits = (data == 16'd0) ? LFSR_RESET : data;
		default: ;
		endcase
	endfunction

	// Galois step to the right; the bit drawn is the low bit before the shift.
	function bit draw_side();
		bit take_left;
		take_left = side_bits[0];
		side_bits = side_bits >> 1;
		if (take_left)
			side_bits = side_bits ^ LFSR_MASK;
		return take_left;
	endfunction

	// One in-place pass from the bottom-right cell to the top-left cell.
	function bit sweep_grid();
		int w;
		int h;
		bit any;
		bit here;
		bit above;
		w = cols_in_use();
		h = rows_in_use();
		any = 1'b0;
		for (int r = h - 1; r >= 0; r--) begin
			for (int c = w - 1; c >= 0; c--) begin
				here = cells[r][c];
				above = (r > 0) ? cells[r-1][c] : 1'b0;
				if (r > 0 && !here && above) begin
					cells[r][c] = 1'b1;
					cells[r-1][c] = 1'b0;
					any = 1'b1;
				end else if (r > 0 && c > 0 && here && above && !cells[r][c-1]) begin
					cells[r][c-1] = 1'b1;
					cells[r-1][c] = 1'b0;
					any = 1'b1;
				end else if (r > 0 && c + 1 < w && here && above && !cells[r][c+1]) begin
					cells[r][c+1] = 1'b1;
					cells[r-1][c] = 1'b0;
					any = 1'b1;
				end else if (draw_side()) begin
					if (c > 0 && here && !cells[r][c-1]) begin
						cells[r][c-1] = 1'b1;
						cells[r][c] = 1'b0;
						any = 1'b1;
					end
				end else begin
					if (c + 1 < w && here && !cells[r][c+1]) begin
						cells[r][c+1] = 1'b1;
						cells[r][c] = 1'b0;
						any = 1'b1;
					end
				end
			end
		end
		return any;
	endfunction

	function void note_item(logic [1:0] m, logic [5:0] r, logic [5:0] c, logic v);
		cell_readout_t due;
		bit            in_area;
		due.cell_out = 1'b0;
		due.moved = 1'b0;
		in_area = (r < rows_in_use()) && (c < cols_in_use());
		case (m)
		MODE_WRITE: begin
			if (in_area)
				cells[r][c] = v;
		end
		MODE_READ: begin
			if (in_area)
				due.cell_out = cells[r][c];
			if (due.cell_out)
				water_reads++;
		end
		MODE_SWEEP: begin
			due.moved = sweep_grid();
			sweeps++;
			if (due.moved)
				sweeps_moved++;
		end
		default: ;
		endcase
		readouts_due.push_back(due);
	endfunction

	task report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		errors++;
	endtask

	task check_result(logic got_cell, logic got_moved);
		cell_readout_t due;
		if (readouts_due.size() == 0) begin
			report_mismatch($sformatf("readout cell_out=%b moved=%b with no item outstanding",
				got_cell, got_moved));
			return;
		end
		due = readouts_due.pop_front();
		checked++;
		if (got_cell !== due.cell_out)
			report_mismatch($sformatf("readout %0d: cell_out=%b, predicted %b",
				checked, got_cell, due.cell_out));
		if (got_moved !== due.moved)
			report_mismatch($sformatf("readout %0d: moved=%b, predicted %b",
				checked, got_moved, due.moved));
	endtask

	function int outstanding();
		return readouts_due.size();
	endfunction
endclass

module falling_water_grid_sweep_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD      = 12;
	localparam int RESET_CYCLES    = 5;
	// The whole run, full 64 by 64 sweeps included, stays far below this limit.
	localparam int TIMEOUT_CYCLES  = 5_000_000;
	// Cycles to let pass once nothing is outstanding, before a register write or the end.
	localparam int SETTLE_CYCLES   = 16;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 13;
	localparam int PRESSURE_PHASE  = 4;
	localparam int HOLD_CYCLES     = 400;

	// Mode 3 is not given a name by the package; it must do nothing at all.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [1:0]            cfg_index = REG_GRID_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            mode = MODE_WRITE;
	logic [5:0]            row = '0;
	logic [5:0]            col = '0;
	logic                  cell_in = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  cell_out;
	logic                  moved;

	// Chance, in percent, that the sender idles or the receiver stalls in a given cycle.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// Set by the stimulus to make the receiver hold off in one unbroken run.
	bit hold_request = 1'b0;
	int items_sent = 0;
	int settings_used = 0;

	water_scoreboard sb = new();

	falling_water_grid_sweep i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.row       (row),
		.col       (col),
		.cell_in   (cell_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cell_out  (cell_out),
		.moved     (moved)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	// Both channels are watched at the rising edge, where the values seen are the
	// ones the block itself samples. An accepted item is noted before the readout
	// of the same edge is checked, so a fast block cannot overtake the prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(mode, row, col, cell_in);
			if (out_valid && out_ready)
				sb.check_result(cell_out, moved);
		end
	end

	// The receiver. It stalls at random at the rate of the current phase, and on
	// request holds off for a long stretch so that a result sits in the output
	// register, the next item is taken in behind it and the input backs up.
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offers one item and returns at the edge where it is accepted. Idle cycles
	// go in front of the item; with no idling, valid stays high from one item to
	// the next and only the payload changes.
	task automatic send_item(input logic [1:0] m, input logic [5:0] r, input logic [5:0] c,
			input logic v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		row <= r;
		col <= c;
		cell_in <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Waits until every readout has come back and the block has had time to settle,
	// so that registers can be written safely. The first edge lets the monitor note
	// an item accepted at the edge where the caller returned.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Writes all three registers on back-to-back edges; the enable stays high
	// throughout and drops only after the last one.
	task automatic set_grid(input logic [15:0] w, input logic [15:0] h, input logic [15:0] seed);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= w;
		sb.write_register(REG_GRID_WIDTH, w);
		@(posedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data <= h;
		sb.write_register(REG_GRID_HEIGHT, h);
		@(posedge clk);
		cfg_index <= REG_RANDOM_SEED;
		cfg_data <= seed;
		sb.write_register(REG_RANDOM_SEED, seed);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Grid sizes are mostly small so that sweeps stay short. Now and then a size is
	// zero, which leaves no cell in use, or at or above the largest, which the
	// block must clip to 64.
	function automatic logic [15:0] pick_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 4)
			return 16'd0;
		if (roll < 14)
			return 16'($urandom_range(127, 64));
		return 16'($urandom_range(10, 1));
	endfunction

	// Most items fill the used area with water, read it back or sweep it, so that water falls,
	// slides and spreads over several sweeps. The rest land anywhere in the
	// 64 by 64 space, including outside the area in use, or carry mode 3.
	task automatic send_random_item();
		int         roll;
		int         w;
		int         h;
		logic [5:0] r;
		logic [5:0] c;
		logic       v;
		w = sb.cols_in_use();
		h = sb.rows_in_use();
		r = 6'($urandom_range(63));
		c = 6'($urandom_range(63));
		if (w > 0 && h > 0 && $urandom_range(99) >= 15) begin
			r = 6'($urandom_range(h - 1));
			c = 6'($urandom_range(w - 1));
		end
		roll = $urandom_range(99);
		if (roll < 50) begin
			v = ($urandom_range(99) < 70);
			send_item(MODE_WRITE, r, c, v);
		end else if (roll < 75) begin
			send_item(MODE_READ, r, c, 1'($urandom_range(1)));
		end else if (roll < 96) begin
			send_item(MODE_SWEEP, r, c, 1'($urandom_range(1)));
		end else begin
			send_item(MODE_UNUSED, r, c, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed part. First the reset values: a 64 by 64 grid, all empty, seed 1.
		// The corner cells carry the extremes of row, column and cell value.
		send_item(MODE_WRITE, 6'd0, 6'd0, 1'b1);
		send_item(MODE_WRITE, 6'd63, 6'd63, 1'b1);
		send_item(MODE_READ, 6'd63, 6'd63, 1'b0);
		send_item(MODE_READ, 6'd0, 6'd0, 1'b0);
		send_item(MODE_WRITE, 6'd63, 6'd63, 1'b0);
		send_item(MODE_READ, 6'd63, 6'd63, 1'b1);
		// A full-size sweep: the water in the top-left corner falls one row.
		send_item(MODE_SWEEP, 6'd0, 6'd0, 1'b0);
		send_item(MODE_READ, 6'd1, 6'd0, 1'b0);
		// Mode 3 must change nothing and return zeros.
		send_item(MODE_UNUSED, 6'd63, 6'd63, 1'b1);

		// A 3 by 3 grid, with junk above the seven size bits of the width write.
		// A column of water in the middle exercises the fall, both slides and
		// the random sideways move over two sweeps.
		wait_idle();
		set_grid(16'h0103, 16'd3, 16'hACE1);
		send_item(MODE_WRITE, 6'd0, 6'd1, 1'b1);
		send_item(MODE_WRITE, 6'd1, 6'd1, 1'b1);
		send_item(MODE_WRITE, 6'd2, 6'd1, 1'b1);
		send_item(MODE_SWEEP, 6'd0, 6'd0, 1'b0);
		send_item(MODE_READ, 6'd2, 6'd0, 1'b0);
		send_item(MODE_READ, 6'd2, 6'd2, 1'b0);
		send_item(MODE_SWEEP, 6'd0, 6'd0, 1'b0);
		// Outside the used area a write is dropped and a read gives empty.
		send_item(MODE_WRITE, 6'd5, 6'd40, 1'b1);
		send_item(MODE_READ, 6'd5, 6'd40, 1'b0);
		send_item(MODE_READ, 6'd2, 6'd63, 1'b0);

		// Zero width: no cell is in use and a sweep reports nothing. A zero seed
		// must be taken as 1.
		wait_idle();
		set_grid(16'd0, 16'd4, 16'd0);
		send_item(MODE_SWEEP, 6'd0, 6'd0, 1'b0);
		send_item(MODE_READ, 6'd0, 6'd0, 1'b0);

		// Oversized width and height fall back to the full 64 by 64 grid.
		wait_idle();
		set_grid(16'd127, 16'd100, 16'hFFFF);
		send_item(MODE_WRITE, 6'd62, 6'd63, 1'b1);
		send_item(MODE_SWEEP, 6'd0, 6'd0, 1'b0);
		send_item(MODE_READ, 6'd63, 6'd63, 1'b0);

		// Random part. Each phase picks a new grid setting and its own idling:
		// none, sender idle, receiver stalling, and both. One phase with no idling
		// also has the receiver hold off for a long stretch.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			set_grid(pick_size(), pick_size(), 16'($urandom_range(16'hFFFF)));
			case (p % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 62;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 62;
			end
			default: begin
				send_idle_pct = 20;
				recv_stall_pct = 20;
			end
			endcase
			if (p == PRESSURE_PHASE)
				hold_request = 1'b1;
			repeat (ITEMS_PER_PHASE)
				send_random_item();
		end

		// Every readout must be in before the verdict; a readout that never comes
		// ends the run through the timeout instead.
		wait_idle();
		$display("Covered %0d items over %0d grid settings; %0d readouts checked.",
			items_sent, settings_used, sb.checked);
		$display("Sweeps: %0d, of which %0d moved water; reads that found water: %0d.",
			sb.sweeps, sb.sweeps_moved, sb.water_reads);
		if (sb.errors == 0) begin
			$display("falling_water_grid_sweep_test passed");
		end else begin
			$display("falling_water_grid_sweep_test failed");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Timeout with %0d readouts outstanding.", sb.outstanding());
		$display("falling_water_grid_sweep_test failed");
		$finish;
	end
endmodule
